### src/swvp_pkg.sv
`default_nettype none

package swvp_pkg;

	// Data word and reported count widths
	localparam int unsigned WORD_W  = 32;
	localparam int unsigned COUNT_W = 9;

	// Operation codes
	typedef enum logic [1:0] {
		OP_PUSH  = 2'd0,
		OP_POP   = 2'd1,
		OP_PURGE = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_POP_RD,
		ST_PURGE
	} state_t;

endpackage

`default_nettype wire

### src/stack_with_value_purge.sv
`default_nettype none

// LIFO stack of signed 32-bit words with push, pop and purge-by-value. Every
// accepted word yields one result word carrying the new top entry (0 when
// empty), an empty flag, the low 9 bits of the entry count and a flag set
// only when a push was dropped on a full stack. Entries live in a single
// RAM with one write and one registered read port, so timing is set by
// that read port: push, no-op, a pop that empties the stack and any
// operation on an empty stack have their result registered as they are
// accepted; a pop that leaves entries waits for one RAM read for the new
// top; a purge walks every held entry through one comparator (accept, one
// read per entry, the last compare and a closing step). No new word is
// taken until the current one is done. The RAM needs no clearing after
// reset: only entries below the count are ever used.
module stack_with_value_purge #(
	parameter int unsigned STACK_DEPTH = 256
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [1:0]                    operation,
	input  wire logic signed [swvp_pkg::WORD_W-1:0]  value,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic signed [swvp_pkg::WORD_W-1:0] top_value,
	output logic                               is_empty,
	output logic [swvp_pkg::COUNT_W-1:0]       entry_count,
	output logic                               overflow
);

	import swvp_pkg::*;

	localparam int unsigned AW = $clog2(STACK_DEPTH);
	localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);
	localparam logic [CW-1:0] ONE_C   = CW'(1);
	localparam logic [CW-1:0] TWO_C   = CW'(2);

	state_t state_q, state_d;

	logic [CW-1:0]     count_q, count_d;
	logic [WORD_W-1:0] top_q, top_d;
	logic [CW-1:0]     rd_q, rd_d;
	logic [CW-1:0]     wr_q, wr_d;
	logic [WORD_W-1:0] word_q, word_d;
	logic              cmp_v_s1, cmp_v_d;

	logic              accept;
	logic              out_free;
	logic              emit;
	logic              ovf_d;
	op_t               op;
	logic [CW-1:0]     pop_idx;
	logic [CW+COUNT_W-1:0] count_ext;

	logic              ram_wr_en;
	logic [AW-1:0]     ram_wr_addr;
	logic [WORD_W-1:0] ram_wr_data;
	logic [AW-1:0]     ram_rd_addr;
	logic [WORD_W-1:0] ram_rd_data;

	logic              out_valid_q;
	logic [WORD_W-1:0] out_top_q;
	logic              out_empty_q;
	logic [COUNT_W-1:0] out_cnt_q;
	logic              out_ovf_q;

	// Handshake
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE) || !out_free;
	assign accept   = in_valid && !in_stall;
	assign op       = op_t'(operation);
	assign pop_idx  = count_q - TWO_C;

	// Entry store
	swvp_ram #(
		.WIDTH(WORD_W),
		.DEPTH(STACK_DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (ram_wr_en),
		.wr_addr(ram_wr_addr),
		.wr_data(ram_wr_data),
		.rd_addr(ram_rd_addr),
		.rd_data(ram_rd_data)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (op == OP_POP && count_q > ONE_C) begin
						state_d = ST_POP_RD;
					end else if (op == OP_PURGE && count_q != '0) begin
						state_d = ST_PURGE;
					end
				end
			end
			ST_POP_RD: begin
				state_d = ST_IDLE;
			end
			ST_PURGE: begin
				if (rd_q == count_q && !cmp_v_s1) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Datapath control: RAM access, counters, shared comparator
	always_comb begin
		count_d     = count_q;
		top_d       = top_q;
		rd_d        = rd_q;
		wr_d        = wr_q;
		word_d      = word_q;
		cmp_v_d     = cmp_v_s1;
		emit        = 1'b0;
		ovf_d       = 1'b0;
		ram_wr_en   = 1'b0;
		ram_wr_addr = wr_q[AW-1:0];
		ram_wr_data = ram_rd_data;
		ram_rd_addr = rd_q[AW-1:0];
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (op)
						OP_PUSH: begin
							emit = 1'b1;
							if (count_q < DEPTH_C) begin
								ram_wr_en   = 1'b1;
								ram_wr_addr = count_q[AW-1:0];
								ram_wr_data = value;
								count_d     = count_q + ONE_C;
								top_d       = value;
							end else begin
								ovf_d = 1'b1;
							end
						end
						OP_POP: begin
							if (count_q > ONE_C) begin
								count_d     = count_q - ONE_C;
								ram_rd_addr = pop_idx[AW-1:0];
							end else begin
								count_d = '0;
								top_d   = '0;
								emit    = 1'b1;
							end
						end
						OP_PURGE: begin
							if (count_q != '0) begin
								word_d  = value;
								rd_d    = '0;
								wr_d    = '0;
								top_d   = '0;
								cmp_v_d = 1'b0;
							end else begin
								emit = 1'b1;
							end
						end
						OP_NOP: begin
							emit = 1'b1;
						end
						default: begin
							emit = 1'b1;
						end
					endcase
				end
			end
			ST_POP_RD: begin
				top_d = ram_rd_data;
				emit  = 1'b1;
			end
			ST_PURGE: begin
				// issue next read
				if (rd_q < count_q) begin
					rd_d    = rd_q + ONE_C;
					cmp_v_d = 1'b1;
				end else begin
					cmp_v_d = 1'b0;
				end
				// keep entries that differ, compacting toward the bottom
				if (cmp_v_s1 && ram_rd_data != word_q) begin
					ram_wr_en = 1'b1;
					wr_d      = wr_q + ONE_C;
					top_d     = ram_rd_data;
				end
				if (rd_q == count_q && !cmp_v_s1) begin
					count_d = wr_q;
					emit    = 1'b1;
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	assign count_ext = (CW + COUNT_W)'(count_d);

	// Control and state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			top_q    <= '0;
			rd_q     <= '0;
			wr_q     <= '0;
			cmp_v_s1 <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			top_q    <= top_d;
			rd_q     <= rd_d;
			wr_q     <= wr_d;
			cmp_v_s1 <= cmp_v_d;
		end
	end

	always_ff @(posedge clk) begin
		word_q <= word_d;
	end

	// Result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_top_q   <= top_d;
			out_empty_q <= (count_d == '0);
			out_cnt_q   <= count_ext[COUNT_W-1:0];
			out_ovf_q   <= ovf_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign top_value   = out_top_q;
	assign is_empty    = out_empty_q;
	assign entry_count = out_cnt_q;
	assign overflow    = out_ovf_q;

	// Checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("entry count above depth");

	a_purge_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PURGE |-> wr_q <= rd_q && rd_q <= count_q)
		else $error("purge write pointer passed read pointer");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		accept && op == OP_PUSH && count_q < DEPTH_C |=> count_q == $past(count_q) + ONE_C)
		else $error("push did not grow the stack");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		accept && op == OP_PUSH && count_q == DEPTH_C |=> out_valid && overflow)
		else $error("dropped push not flagged");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> out_free)
		else $error("result word overwritten");

endmodule

`default_nettype wire

### src/swvp_ram.sv
`default_nettype none

module swvp_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

`default_nettype wire

### tb/sv/stack_with_value_purge_tb.sv
`default_nettype none

module stack_with_value_purge_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import swvp_pkg::*;

	localparam int unsigned DEPTH     = 256;
	// Bound on the run, high enough for purges of a full stack plus stalls and gaps
	localparam int unsigned RUN_LIMIT = 1200000;

	// One expected result word
	typedef struct packed {
		logic signed [31:0] top;
		logic               empty;
		logic [8:0]         count;
		logic               ovf;
	} stack_result_t;

	// Stack predictor and store of expected result words
	class stack_scoreboard;
		logic [31:0]   entries [DEPTH];
		int unsigned   fill = 0;
		stack_result_t pending [$];
		int unsigned   errors = 0;
		int unsigned   words_checked = 0;
		int unsigned   pushes_dropped = 0;
		int unsigned   purged_entries = 0;
		int unsigned   deepest = 0;

		// Apply one accepted word to the predicted stack and queue its result
		function void note_word(op_t op, logic [31:0] w);
			stack_result_t r;
			int unsigned   keep;
			int unsigned   i;
			logic          ovf;
			ovf = 1'b0;
			case (op)
				OP_PUSH: begin
					if (fill < DEPTH) begin
						entries[fill] = w;
						fill++;
					end else begin
						ovf = 1'b1;
						pushes_dropped++;
					end
				end
				OP_POP: begin
					if (fill > 0)
						fill--;
				end
				OP_PURGE: begin
					// compact survivors toward the bottom, order kept
					keep = 0;
					for (i = 0; i < fill; i++) begin
						if (entries[i] !== w) begin
							entries[keep] = entries[i];
							keep++;
						end
					end
					purged_entries += fill - keep;
					fill = keep;
				end
				default: ;
			endcase
			if (fill > deepest)
				deepest = fill;
			r.top   = (fill > 0) ? entries[fill - 1] : 32'sd0;
			r.empty = (fill == 0);
			r.count = fill[8:0];
			r.ovf   = ovf;
			pending.push_back(r);
		endfunction

		// Compare one accepted result word with the oldest expectation
		function void check_result(logic [31:0] top, logic empty, logic [8:0] count,
				logic ovf);
			stack_result_t want;
			if (pending.size() == 0) begin
				$display("%0t: result word with none expected: top_value %h count %0d",
					$time, top, count);
				errors++;
				return;
			end
			want = pending.pop_front();
			words_checked++;
			if (top !== want.top) begin
				$display("%0t: top_value expected %h actual %h", $time, want.top, top);
				errors++;
			end
			if (empty !== want.empty) begin
				$display("%0t: is_empty expected %b actual %b", $time, want.empty, empty);
				errors++;
			end
			if (count !== want.count) begin
				$display("%0t: entry_count expected %0d actual %0d", $time, want.count, count);
				errors++;
			end
			if (ovf !== want.ovf) begin
				$display("%0t: overflow expected %b actual %b", $time, want.ovf, ovf);
				errors++;
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         operation;
	logic signed [31:0] value;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] top_value;
	logic               is_empty;
	logic [8:0]         entry_count;
	logic               overflow;

	int unsigned        send_idle_pct = 0;
	int unsigned        recv_stall_pct = 0;
	int unsigned        cycles = 0;
	stack_scoreboard    sb;

	stack_with_value_purge dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.operation  (operation),
		.value      (value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.top_value  (top_value),
		.is_empty   (is_empty),
		.entry_count(entry_count),
		.overflow   (overflow)
	);

	always #2 clk = ~clk;

	// Receiver stall
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(top_value, is_empty, entry_count, overflow);
	end

	// Run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == RUN_LIMIT) begin
			$display("%0t: run limit reached, %0d result words outstanding", $time,
				sb.pending.size());
			$display("Some tests failed");
			$finish;
		end
	end

	// Offer one word after a random gap; returns at the edge it is taken
	task automatic send_word(input op_t op, input logic [31:0] w);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(posedge clk);
		end
		in_valid  <= 1'b1;
		operation <= op;
		value     <= w;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_word(op, w);
	endtask

	// Half the words come from a small pool so purges find matches
	function automatic logic [31:0] pick_word();
		logic [31:0] pool [8];
		pool = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h0000_0001, 32'h5A5A_5A5A, 32'hA5A5_A5A5, 32'h0000_002A};
		if ($urandom_range(99) < 50)
			return pool[$urandom_range(7)];
		return $urandom();
	endfunction

	task automatic send_random_word(input int unsigned push_pct, input int unsigned purge_pct);
		int unsigned r;
		op_t         op;
		r = $urandom_range(99);
		if (r < push_pct)
			op = OP_PUSH;
		else if (r < push_pct + purge_pct)
			op = OP_PURGE;
		else if (r >= 96)
			op = OP_NOP;
		else
			op = OP_POP;
		send_word(op, pick_word());
	endtask

	initial begin
		sb        = new();
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		operation = OP_NOP;
		value     = '0;
		out_stall = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty-stack corners, field extremes, purge keeping order
		send_word(OP_POP, 32'h0000_0000);
		send_word(OP_PURGE, 32'h0000_0000);
		send_word(OP_NOP, 32'hFFFF_FFFF);
		send_word(OP_PUSH, 32'h7FFF_FFFF);
		send_word(OP_PUSH, 32'h8000_0000);
		send_word(OP_PUSH, 32'h0000_0000);
		send_word(OP_PUSH, 32'hFFFF_FFFF);
		send_word(OP_PUSH, 32'h8000_0000);
		send_word(OP_PUSH, 32'h0000_0001);
		send_word(OP_NOP, 32'h0000_0000);
		send_word(OP_PURGE, 32'h8000_0000);
		send_word(OP_PURGE, 32'h0000_3039);
		send_word(OP_POP, 32'h0000_0000);
		send_word(OP_PURGE, 32'h7FFF_FFFF);
		send_word(OP_POP, 32'hFFFF_FFFF);
		send_word(OP_POP, 32'h0000_0000);
		send_word(OP_POP, 32'h0000_0000);

		// No idling: fill past full so pushes get dropped, then mixed traffic
		repeat (264) send_word(OP_PUSH, pick_word());
		send_word(OP_NOP, 32'h0000_0000);
		repeat (36) send_random_word(50, 10);

		// Sender mostly idle
		send_idle_pct  = 81;
		recv_stall_pct = 0;
		repeat (250) send_random_word(45, 12);

		// Receiver mostly stalling
		send_idle_pct  = 0;
		recv_stall_pct = 81;
		repeat (250) send_random_word(55, 8);

		// Both sides idling; pop-heavy so the stack drains and pops hit empty
		send_idle_pct  = 29;
		recv_stall_pct = 29;
		repeat (250) send_random_word(40, 10);

		in_valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (DEPTH + 8) @(posedge clk);

		$display("Checked %0d result words: %0d dropped pushes, %0d entries purged,",
			sb.words_checked, sb.pushes_dropped, sb.purged_entries);
		$display("deepest fill %0d of %0d, over idle, stall and mixed phases",
			sb.deepest, DEPTH);
		if (sb.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

`default_nettype wire
